// ----- hw/rtl/imusc_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and tables for the imu sample conditioner
// no dependencies; imported by every module of the block

package imusc_pkg;

  localparam int AngleIterationsDefault = 16;
  localparam int SqrtInW  = 40;
  localparam int SqrtOutW = 20;

  typedef enum logic [2:0] {
    CFG_ACCEL_RANGE    = 3'd0,
    CFG_GYRO_RANGE     = 3'd1,
    CFG_ACCEL_OFFSET_X = 3'd2,
    CFG_ACCEL_OFFSET_Y = 3'd3,
    CFG_ACCEL_OFFSET_Z = 3'd4,
    CFG_ACCEL_SMOOTH   = 3'd5,
    CFG_GYRO_SMOOTH    = 3'd6
  } cfg_index_t;

  typedef enum logic [2:0] {
    OPK_RSCALE,
    OPK_AFILT,
    OPK_RFILT,
    OPK_ASQ,
    OPK_RSQ
  } op_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_USE,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_CORDIC_GO,
    ST_CORDIC_WAIT,
    ST_FINISH
  } state_t;

  // rate scale factors in q24: 64/131, 64/65.5, 64/32.8, 64/16.4
  function automatic logic [25:0] rate_recip(input logic [1:0] sel);
    logic [25:0] r;
    case (sel)
      2'd0:    r = 26'd8196502;
      2'd1:    r = 26'd16393005;
      2'd2:    r = 26'd32736031;
      default: r = 26'd65472062;
    endcase
    return r;
  endfunction

  // atan(2^-i) in 2^-16 degree
  function automatic logic [21:0] atan_entry(input logic [4:0] i);
    logic [21:0] r;
    case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [19:0] sat_accel(input logic signed [27:0] v);
    logic signed [19:0] r;
    if (v > 28'sd524287) r = 20'sd524287;
    else if (v < -28'sd524288) r = -20'sd524288;
    else r = v[19:0];
    return r;
  endfunction

  function automatic logic signed [18:0] sat_rate(input logic signed [27:0] v);
    logic signed [18:0] r;
    if (v > 28'sd262143) r = 19'sd262143;
    else if (v < -28'sd262144) r = -19'sd262144;
    else r = v[18:0];
    return r;
  endfunction

endpackage

// ----- hw/rtl/imusc_sqrt.sv -----
`timescale 1ns / 1ps
// floor integer square root, restoring method, one result bit per cycle
// depends on imusc_pkg

module imusc_sqrt import imusc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [SqrtInW-1:0]    radicand,
  output logic                  done,
  output logic [SqrtOutW-1:0]   root
);

  localparam int RemW = SqrtOutW + 3;

  logic [SqrtInW-1:0] rad;
  logic [RemW-1:0]    rem;
  logic [4:0]         cnt;
  logic               busy;
  logic [RemW-1:0]    rem_sh;
  logic [RemW-1:0]    trial;

  assign rem_sh = {rem[RemW-3:0], rad[SqrtInW-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
      end else if (busy) begin
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[SqrtOutW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[SqrtOutW-2:0], 1'b0};
        end
        rad <= rad << 2;
        cnt <= cnt + 5'd1;
        if (cnt == 5'(SqrtOutW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/imusc_cordic.sv -----
`timescale 1ns / 1ps
// vectoring cordic atan2, one rotation per cycle, result in 1/128 degree
// depends on imusc_pkg for the arctangent table

module imusc_cordic import imusc_pkg::*; #(
  parameter int ITERATIONS = AngleIterationsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [20:0] y_in,
  input  logic signed [20:0] x_in,
  output logic               done,
  output logic signed [15:0] angle
);

  localparam int CntW = $clog2(ITERATIONS + 1);

  logic signed [32:0] x, y;
  logic signed [25:0] z;
  logic [CntW-1:0]    cnt;
  logic               busy;
  logic [4:0]         idx;
  logic signed [32:0] xs, ys, dx, dy;
  logic signed [25:0] step_z;
  logic signed [26:0] z_rnd;
  logic signed [17:0] z_q;

  assign idx    = 5'(cnt);
  assign xs     = {{12{x_in[20]}}, x_in} <<< 8;
  assign ys     = {{12{y_in[20]}}, y_in} <<< 8;
  assign dx     = y >>> idx;
  assign dy     = x >>> idx;
  assign step_z = $signed({4'b0, atan_entry(idx)});
  assign z_rnd  = {z[25], z} + 27'sd256;
  assign z_q    = z_rnd[26:9];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= '0;
        if (x_in == '0 && y_in == '0) begin
          // zero vector reads as zero angle
          angle <= '0;
          done  <= 1'b1;
        end else begin
          busy <= 1'b1;
          if (x_in < 0) begin
            x <= -xs;
            y <= -ys;
            z <= (y_in >= 0) ? 26'sd11796480 : -26'sd11796480;
          end else begin
            x <= xs;
            y <= ys;
            z <= '0;
          end
        end
      end else if (busy) begin
        if (cnt == CntW'(ITERATIONS)) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (z_q > 18'sd23040) angle <= 16'sd23040;
          else if (z_q < -18'sd23040) angle <= -16'sd23040;
          else angle <= z_q[15:0];
        end else begin
          cnt <= cnt + 1'b1;
          if (!y[32]) begin
            x <= x + dx;
            y <= y - dy;
            z <= z + step_z;
          end else begin
            x <= x - dx;
            y <= y + dy;
            z <= z - step_z;
          end
        end
      end
    end
  end

endmodule

// ----- hw/rtl/imu_sample_conditioner.sv -----
`timescale 1ns / 1ps
// Conditions one six-axis sample per beat: scaling, offset, exponential filter,
// magnitudes and pitch/roll. A sample is taken only when the block is idle and
// then passes through fifteen multiply/use steps on the one shared 28x22
// multiplier, three passes of the bit-serial square root and two cordic runs
// (a zero input vector gives a zero angle without rotating) before the finish
// state. The result sits in an output register, so the next sample can be
// taken while it waits; that sample then holds in its finish state until the
// previous result has left.
// Depends on imusc_pkg, imusc_sqrt and imusc_cordic.

module imu_sample_conditioner import imusc_pkg::*; #(
  parameter int ANGLE_ITERATIONS = AngleIterationsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  logic signed [15:0] raw_accel_x,
  input  logic signed [15:0] raw_accel_y,
  input  logic signed [15:0] raw_accel_z,
  input  logic signed [15:0] raw_rate_x,
  input  logic signed [15:0] raw_rate_y,
  input  logic signed [15:0] raw_rate_z,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [19:0] accel_x_filtered,
  output logic signed [19:0] accel_y_filtered,
  output logic signed [19:0] accel_z_filtered,
  output logic signed [18:0] rate_x_filtered,
  output logic signed [18:0] rate_y_filtered,
  output logic signed [18:0] rate_z_filtered,
  output logic [19:0]        accel_magnitude,
  output logic [18:0]        rate_magnitude,
  output logic signed [15:0] pitch_angle,
  output logic signed [15:0] roll_angle,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata
);

  // configuration
  logic [1:0]         accel_range;
  logic [1:0]         gyro_range;
  logic signed [15:0] accel_offset [3];
  logic [15:0]        accel_smooth;
  logic [15:0]        gyro_smooth;

  // sample and working state
  logic signed [15:0] raw_a [3];
  logic signed [15:0] raw_r [3];
  logic signed [18:0] rate_scaled [3];
  logic signed [19:0] accel_filt [3];
  logic signed [18:0] rate_filt [3];
  logic               filter_primed;
  logic [39:0]        sum_a, sum_yz, sum_r;
  logic [19:0]        yz_root, amag, rmag_w;
  logic signed [15:0] pitch, roll;

  state_t   state, state_next;
  op_kind_t kind;
  logic [1:0] axis;
  logic [1:0] sqrt_sel;
  logic       cordic_sel;
  logic       sqrt_start, cordic_start, load_result, take_sample;

  // shared multiplier
  logic signed [27:0] mul_a;
  logic signed [21:0] mul_b;
  logic signed [49:0] prod;

  // per-axis datapath
  logic signed [15:0] raw_sel, off_sel;
  logic signed [19:0] raw_shift;
  logic signed [20:0] acc_diff;
  logic signed [19:0] acc_new;
  logic signed [41:0] a_num, r_num;
  logic signed [49:0] r_scl;
  logic [SqrtInW-1:0] sqrt_rad;
  logic               sqrt_done, cordic_done;
  logic [SqrtOutW-1:0] sqrt_root;
  logic signed [20:0] cy, cx;
  logic signed [15:0] cordic_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_range  <= 2'd2;
      gyro_range   <= 2'd1;
      accel_offset <= '{default: '0};
      accel_smooth <= '0;
      gyro_smooth  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ACCEL_RANGE:    accel_range     <= cfg_wdata[1:0];
        CFG_GYRO_RANGE:     gyro_range      <= cfg_wdata[1:0];
        CFG_ACCEL_OFFSET_X: accel_offset[0] <= cfg_wdata;
        CFG_ACCEL_OFFSET_Y: accel_offset[1] <= cfg_wdata;
        CFG_ACCEL_OFFSET_Z: accel_offset[2] <= cfg_wdata;
        CFG_ACCEL_SMOOTH:   accel_smooth    <= cfg_wdata;
        CFG_GYRO_SMOOTH:    gyro_smooth     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign raw_sel   = raw_a[axis];
  assign off_sel   = accel_offset[axis];
  assign raw_shift = {{4{raw_sel[15]}}, raw_sel} <<< accel_range;
  assign acc_diff  = {raw_shift[19], raw_shift} - {{5{off_sel[15]}}, off_sel};
  assign acc_new   = sat_accel({{7{acc_diff[20]}}, acc_diff});

  always_comb begin
    case (kind)
      OPK_RSCALE: begin
        mul_a = $signed({2'b0, rate_recip(gyro_range)});
        mul_b = {{6{raw_r[axis][15]}}, raw_r[axis]};
      end
      OPK_AFILT: begin
        mul_a = $signed({12'b0, accel_smooth});
        mul_b = {{2{accel_filt[axis][19]}}, accel_filt[axis]} - {{2{acc_new[19]}}, acc_new};
      end
      OPK_RFILT: begin
        mul_a = $signed({12'b0, gyro_smooth});
        mul_b = {{3{rate_filt[axis][18]}}, rate_filt[axis]}
                - {{3{rate_scaled[axis][18]}}, rate_scaled[axis]};
      end
      OPK_ASQ: begin
        mul_a = {{8{accel_filt[axis][19]}}, accel_filt[axis]};
        mul_b = {{2{accel_filt[axis][19]}}, accel_filt[axis]};
      end
      default: begin
        mul_a = {{9{rate_filt[axis][18]}}, rate_filt[axis]};
        mul_b = {{3{rate_filt[axis][18]}}, rate_filt[axis]};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_ISSUE) prod <= mul_a * mul_b;
  end

  // new*65536 + alpha*(old-new), rounded
  assign a_num = $signed({{6{acc_new[19]}}, acc_new, 16'b0}) + prod[41:0] + 42'sd32768;
  assign r_num = $signed({{7{rate_scaled[axis][18]}}, rate_scaled[axis], 16'b0})
                 + prod[41:0] + 42'sd32768;
  assign r_scl = prod + 50'sd8388608;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_primed <= 1'b0;
    end else begin
      if (take_sample) begin
        raw_a  <= '{raw_accel_x, raw_accel_y, raw_accel_z};
        raw_r  <= '{raw_rate_x, raw_rate_y, raw_rate_z};
        sum_a  <= '0;
        sum_yz <= '0;
        sum_r  <= '0;
      end
      if (state == ST_USE) begin
        case (kind)
          OPK_RSCALE: rate_scaled[axis] <= sat_rate({{2{r_scl[49]}}, r_scl[49:24]});
          OPK_AFILT:  accel_filt[axis] <= filter_primed ?
                        sat_accel({{2{a_num[41]}}, a_num[41:16]}) : acc_new;
          OPK_RFILT: begin
            rate_filt[axis] <= filter_primed ?
              sat_rate({{2{r_num[41]}}, r_num[41:16]}) : rate_scaled[axis];
            if (axis == 2'd2) filter_primed <= 1'b1;
          end
          OPK_ASQ: begin
            sum_a <= sum_a + prod[39:0];
            if (axis != 2'd0) sum_yz <= sum_yz + prod[39:0];
          end
          default: sum_r <= sum_r + prod[39:0];
        endcase
      end
      if (sqrt_done) begin
        case (sqrt_sel)
          2'd0:    yz_root <= sqrt_root;
          2'd1:    amag    <= sqrt_root;
          default: rmag_w  <= sqrt_root;
        endcase
      end
      if (cordic_done) begin
        if (cordic_sel) roll <= cordic_angle;
        else pitch <= cordic_angle;
      end
    end
  end

  // sequencer counters
  always_ff @(posedge clk) begin
    if (rst) begin
      kind       <= OPK_RSCALE;
      axis       <= '0;
      sqrt_sel   <= '0;
      cordic_sel <= 1'b0;
    end else begin
      if (take_sample) begin
        kind       <= OPK_RSCALE;
        axis       <= '0;
        sqrt_sel   <= '0;
        cordic_sel <= 1'b0;
      end else if (state == ST_USE) begin
        if (axis == 2'd2) begin
          axis <= '0;
          case (kind)
            OPK_RSCALE: kind <= OPK_AFILT;
            OPK_AFILT:  kind <= OPK_RFILT;
            OPK_RFILT:  kind <= OPK_ASQ;
            default:    kind <= OPK_RSQ;
          endcase
        end else begin
          axis <= axis + 2'd1;
        end
      end
      if (sqrt_done) sqrt_sel <= sqrt_sel + 2'd1;
      if (cordic_done) cordic_sel <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next   = state;
    sample_ready = 1'b0;
    sqrt_start   = 1'b0;
    cordic_start = 1'b0;
    load_result  = 1'b0;
    case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) state_next = ST_ISSUE;
      end
      ST_ISSUE: state_next = ST_USE;
      ST_USE: begin
        if (kind == OPK_RSQ && axis == 2'd2) state_next = ST_SQRT_GO;
        else state_next = ST_ISSUE;
      end
      ST_SQRT_GO: begin
        sqrt_start = 1'b1;
        state_next = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (sqrt_done) state_next = (sqrt_sel == 2'd2) ? ST_CORDIC_GO : ST_SQRT_GO;
      end
      ST_CORDIC_GO: begin
        cordic_start = 1'b1;
        state_next   = ST_CORDIC_WAIT;
      end
      ST_CORDIC_WAIT: begin
        if (cordic_done) state_next = cordic_sel ? ST_FINISH : ST_CORDIC_GO;
      end
      ST_FINISH: begin
        if (!result_valid || result_ready) begin
          load_result = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign take_sample = sample_valid && sample_ready;

  always_comb begin
    case (sqrt_sel)
      2'd0:    sqrt_rad = sum_yz;
      2'd1:    sqrt_rad = sum_a;
      default: sqrt_rad = sum_r;
    endcase
  end

  imusc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqrt_rad),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  assign cy = cordic_sel ? {accel_filt[1][19], accel_filt[1]}
                         : -{accel_filt[0][19], accel_filt[0]};
  assign cx = cordic_sel ? {accel_filt[2][19], accel_filt[2]} : $signed({1'b0, yz_root});

  imusc_cordic #(
    .ITERATIONS (ANGLE_ITERATIONS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .y_in  (cy),
    .x_in  (cx),
    .done  (cordic_done),
    .angle (cordic_angle)
  );

  // output register; rate sum stays below 2^38 so its root fits 19 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      accel_x_filtered <= accel_filt[0];
      accel_y_filtered <= accel_filt[1];
      accel_z_filtered <= accel_filt[2];
      rate_x_filtered  <= rate_filt[0];
      rate_y_filtered  <= rate_filt[1];
      rate_z_filtered  <= rate_filt[2];
      accel_magnitude  <= amag;
      rate_magnitude   <= rmag_w[18:0];
      pitch_angle      <= pitch;
      roll_angle       <= roll;
    end
  end

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_FINISH)
    else $error("result beat raised outside finish");

  a_sqrt_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> state == ST_SQRT_WAIT)
    else $error("square root finished while not awaited");

  a_cordic_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    cordic_done |-> state == ST_CORDIC_WAIT)
    else $error("cordic finished while not awaited");

  a_primed_before_sqrt: assert property (@(posedge clk) disable iff (rst)
    state == ST_SQRT_GO |-> filter_primed)
    else $error("filters not primed after update pass");

endmodule
